// ===== rtl/arwt_pkg.sv =====
// ---------------------------------------------------------------------------
// arwt_pkg - shared types and codes for the address range watch table
// Command opcodes, result status and kind codes, and the queued command type.
// ---------------------------------------------------------------------------
`default_nettype none

package arwt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int READ_CAP          = 64;

    typedef enum logic [1:0] {
        OP_REG   = 2'd0,
        OP_UNREG = 2'd1,
        OP_INV   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOREAD   = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_FINAL  = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [63:0] cookie;
        logic [63:0] rstart;
        logic [63:0] rend;
        logic [6:0]  lim;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/arwt_cmd_queue.sv =====
// ---------------------------------------------------------------------------
// arwt_cmd_queue - command front end
// Accepts transactions, decodes the opcode, clamps the read limit and holds
// up to two commands for the table engine.
// ---------------------------------------------------------------------------
`default_nettype none

module arwt_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     mode,
    input  wire logic [63:0]    cookie,
    input  wire logic [63:0]    range_start,
    input  wire logic [63:0]    range_end,
    input  wire logic [6:0]     max_events,
    output logic                cmd_valid,
    output arwt_pkg::cmd_t      cmd,
    input  wire logic           cmd_pop
);

    arwt_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    arwt_pkg::cmd_t in_cmd;
    logic           push;

    always_comb
    begin
        in_cmd.op     = arwt_pkg::op_t'(mode);
        in_cmd.cookie = cookie;
        in_cmd.rstart = range_start;
        in_cmd.rend   = range_end;
        in_cmd.lim    = (max_events > 7'(arwt_pkg::READ_CAP)) ?
                        7'(arwt_pkg::READ_CAP) : max_events;
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, cmd_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/arwt_engine.sv =====
// ---------------------------------------------------------------------------
// arwt_engine - table walker and event queue
// Carries out one command at a time by walking the range table entry by
// entry, and drives the registered result port.
// ---------------------------------------------------------------------------
`default_nettype none

module arwt_engine #(
    parameter int TABLE_ENTRIES = arwt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire arwt_pkg::cmd_t cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [2:0]          status,
    output logic [1:0]          event_kind,
    output logic                hint_valid,
    output logic [63:0]         cookie_or_count,
    output logic [63:0]         event_start,
    output logic [63:0]         event_end,
    output logic                hit,
    output logic                last
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);
    localparam logic [IW-1:0] IDX_ONE  = IW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_LK_RD, S_LK_CMP, S_REG_DO, S_UNREG_DO,
        S_INV_RD, S_INV_CMP, S_INV_DO, S_INV_FIN,
        S_RD_CHK, S_RD_HEAD, S_RD_WAIT, S_RD_EMIT
    } state_t;

    typedef struct packed {
        logic [63:0] tag;
        logic [63:0] lo;
        logic [63:0] hi;
    } ent_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } hint_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic        hv;
        logic [63:0] coc;
        logic [63:0] es;
        logic [63:0] ee;
        logic        hit;
        logic        last;
    } res_t;

    function automatic res_t mk_res(logic [2:0] st, logic [1:0] kd, logic hv,
                                    logic [63:0] coc, logic [63:0] es,
                                    logic [63:0] ee, logic ht, logic lst);
        res_t r;
        r.status = st;
        r.kind   = kd;
        r.hv     = hv;
        r.coc    = coc;
        r.es     = es;
        r.ee     = ee;
        r.hit    = ht;
        r.last   = lst;
        return r;
    endfunction

    // range memories, one read port at idx_reg, registered
    ent_t  ent_mem  [TABLE_ENTRIES];
    hint_t hint_mem [TABLE_ENTRIES];
    ent_t  ent_rd_reg;
    hint_t hint_rd_reg;
    logic  ent_we;
    logic  hint_we;

    state_t          state_reg;
    arwt_pkg::cmd_t  cmd_reg;
    logic [IW-1:0]   idx_reg;
    logic            found_reg;
    logic [IW-1:0]   fslot_reg;
    logic [IW-1:0]   age_s_reg;
    logic [IW-1:0]   stamp_s_reg;
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] inval_reg;
    logic [TABLE_ENTRIES-1:0] hok_reg;
    logic [TABLE_ENTRIES-1:0] taken_reg;
    logic [IW-1:0]   age_reg   [TABLE_ENTRIES];
    logic [IW-1:0]   stamp_reg [TABLE_ENTRIES];
    logic [CW-1:0]   used_cnt_reg;
    logic [CW-1:0]   qcnt_reg;
    logic            need_empty_reg;
    logic [63:0]     gen_reg;
    logic            hit_reg;
    logic            best_valid_reg;
    logic [63:0]     best_lo_reg;
    logic [63:0]     best_hi_reg;
    logic [IW-1:0]   best_idx_reg;
    logic [IW-1:0]   best_age_reg;
    logic [6:0]      n_reg;
    logic            out_valid_reg;
    res_t            out_reg;

    logic            out_free;
    logic            emit;
    logic [IW-1:0]   free_idx;
    logic [IW-1:0]   head_idx;
    logic            better;
    logic            overlap;
    logic [63:0]     clip_s;
    logic [63:0]     clip_e;

    assign out_free = !out_valid_reg || out_ready;
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;

    // a result is loaded into the output register this cycle
    assign emit = out_free &&
                  ((state_reg == S_REG_DO) || (state_reg == S_UNREG_DO) ||
                   (state_reg == S_INV_FIN) || (state_reg == S_RD_EMIT) ||
                   ((state_reg == S_RD_HEAD) && (qcnt_reg == '0)) ||
                   ((state_reg == S_RD_CHK) &&
                    ((!need_empty_reg && (qcnt_reg == '0)) || (cmd_reg.lim == '0))));

    always_comb
    begin
        free_idx = '0;
        head_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (inval_reg[i] && (stamp_reg[i] == '0))
            begin
                head_idx = IW'(i);
            end
        end
    end

    assign better = used_reg[idx_reg] && !taken_reg[idx_reg] &&
                    (!best_valid_reg || (ent_rd_reg.lo < best_lo_reg) ||
                     ((ent_rd_reg.lo == best_lo_reg) &&
                      (age_reg[idx_reg] > best_age_reg)));
    assign overlap = (best_lo_reg < cmd_reg.rend) && (cmd_reg.rstart < best_hi_reg);
    assign clip_s  = (ent_rd_reg.lo > hint_rd_reg.lo) ? ent_rd_reg.lo : hint_rd_reg.lo;
    assign clip_e  = (ent_rd_reg.hi < hint_rd_reg.hi) ? ent_rd_reg.hi : hint_rd_reg.hi;

    assign ent_we  = (state_reg == S_REG_DO) && out_free && !found_reg &&
                     (used_cnt_reg != FULL_CNT);
    assign hint_we = (state_reg == S_INV_DO) && best_valid_reg && overlap &&
                     !inval_reg[best_idx_reg];

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[free_idx] <= '{tag: cmd_reg.cookie, lo: cmd_reg.rstart,
                                   hi: cmd_reg.rend};
        end
        if (hint_we)
        begin
            hint_mem[best_idx_reg] <= '{lo: cmd_reg.rstart, hi: cmd_reg.rend};
        end
        ent_rd_reg  <= ent_mem[idx_reg];
        hint_rd_reg <= hint_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            inval_reg      <= '0;
            hok_reg        <= '0;
            taken_reg      <= '0;
            used_cnt_reg   <= '0;
            qcnt_reg       <= '0;
            need_empty_reg <= 1'b0;
            gen_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg        <= cmd;
                        idx_reg        <= '0;
                        taken_reg      <= '0;
                        hit_reg        <= 1'b0;
                        best_valid_reg <= 1'b0;
                        n_reg          <= '0;
                        unique case (cmd.op)
                            arwt_pkg::OP_REG,
                            arwt_pkg::OP_UNREG: state_reg <= S_LK_RD;
                            arwt_pkg::OP_INV:   state_reg <= S_INV_RD;
                            arwt_pkg::OP_READ:  state_reg <= S_RD_CHK;
                            default:            state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_LK_RD:
                begin
                    state_reg <= S_LK_CMP;
                end
                S_LK_CMP:
                begin
                    if (used_reg[idx_reg] && (ent_rd_reg.tag == cmd_reg.cookie))
                    begin
                        found_reg   <= 1'b1;
                        fslot_reg   <= idx_reg;
                        age_s_reg   <= age_reg[idx_reg];
                        stamp_s_reg <= stamp_reg[idx_reg];
                        state_reg   <= (cmd_reg.op == arwt_pkg::OP_REG) ?
                                       S_REG_DO : S_UNREG_DO;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= (cmd_reg.op == arwt_pkg::OP_REG) ?
                                     S_REG_DO : S_UNREG_DO;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_ONE;
                        state_reg <= S_LK_RD;
                    end
                end
                S_REG_DO:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (found_reg)
                        begin
                            out_reg <= mk_res(arwt_pkg::ST_DUP, arwt_pkg::KIND_STATUS,
                                              1'b0, '0, '0, '0, 1'b0, 1'b1);
                        end
                        else if (used_cnt_reg == FULL_CNT)
                        begin
                            out_reg <= mk_res(arwt_pkg::ST_FULL, arwt_pkg::KIND_STATUS,
                                              1'b0, '0, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            used_reg[free_idx]  <= 1'b1;
                            inval_reg[free_idx] <= 1'b0;
                            hok_reg[free_idx]   <= 1'b0;
                            age_reg[free_idx]   <= used_cnt_reg[IW-1:0];
                            used_cnt_reg        <= used_cnt_reg + CNT_ONE;
                            out_reg <= mk_res(arwt_pkg::ST_OK, arwt_pkg::KIND_STATUS,
                                              1'b0, '0, '0, '0, 1'b0, 1'b1);
                        end
                    end
                end
                S_UNREG_DO:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (!found_reg)
                        begin
                            out_reg <= mk_res(arwt_pkg::ST_NOTFOUND,
                                              arwt_pkg::KIND_STATUS,
                                              1'b0, '0, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            for (int i = 0; i < TABLE_ENTRIES; i++)
                            begin
                                if (used_reg[i] && (age_reg[i] > age_s_reg))
                                begin
                                    age_reg[i] <= age_reg[i] - IDX_ONE;
                                end
                                if (inval_reg[fslot_reg] && inval_reg[i] &&
                                    (stamp_reg[i] > stamp_s_reg))
                                begin
                                    stamp_reg[i] <= stamp_reg[i] - IDX_ONE;
                                end
                            end
                            if (inval_reg[fslot_reg])
                            begin
                                qcnt_reg <= qcnt_reg - CNT_ONE;
                            end
                            inval_reg[fslot_reg] <= 1'b0;
                            hok_reg[fslot_reg]   <= 1'b0;
                            used_reg[fslot_reg]  <= 1'b0;
                            used_cnt_reg         <= used_cnt_reg - CNT_ONE;
                            out_reg <= mk_res(arwt_pkg::ST_OK, arwt_pkg::KIND_STATUS,
                                              1'b0, '0, '0, '0, 1'b0, 1'b1);
                        end
                    end
                end
                S_INV_RD:
                begin
                    state_reg <= S_INV_CMP;
                end
                S_INV_CMP:
                begin
                    if (better)
                    begin
                        best_valid_reg <= 1'b1;
                        best_lo_reg    <= ent_rd_reg.lo;
                        best_hi_reg    <= ent_rd_reg.hi;
                        best_idx_reg   <= idx_reg;
                        best_age_reg   <= age_reg[idx_reg];
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_INV_DO;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_ONE;
                        state_reg <= S_INV_RD;
                    end
                end
                S_INV_DO:
                begin
                    if (!best_valid_reg)
                    begin
                        state_reg <= S_INV_FIN;
                    end
                    else
                    begin
                        taken_reg[best_idx_reg] <= 1'b1;
                        if (overlap)
                        begin
                            hit_reg <= 1'b1;
                            if (inval_reg[best_idx_reg])
                            begin
                                hok_reg[best_idx_reg] <= 1'b0;
                            end
                            else
                            begin
                                stamp_reg[best_idx_reg] <= qcnt_reg[IW-1:0];
                                qcnt_reg                <= qcnt_reg + CNT_ONE;
                                inval_reg[best_idx_reg] <= 1'b1;
                                hok_reg[best_idx_reg]   <= 1'b1;
                            end
                        end
                        idx_reg        <= '0;
                        best_valid_reg <= 1'b0;
                        state_reg      <= S_INV_RD;
                    end
                end
                S_INV_FIN:
                begin
                    if (out_free)
                    begin
                        gen_reg       <= gen_reg + {63'd0, hit_reg};
                        out_valid_reg <= 1'b1;
                        out_reg <= mk_res(arwt_pkg::ST_OK, arwt_pkg::KIND_STATUS,
                                          1'b0, '0, '0, '0, hit_reg, 1'b1);
                        state_reg     <= S_IDLE;
                    end
                end
                S_RD_CHK:
                begin
                    if (!need_empty_reg && (qcnt_reg == '0))
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg <= mk_res(arwt_pkg::ST_NOREAD, arwt_pkg::KIND_STATUS,
                                              1'b0, '0, '0, '0, 1'b0, 1'b1);
                            state_reg     <= S_IDLE;
                        end
                    end
                    else if (cmd_reg.lim == '0)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg <= mk_res(arwt_pkg::ST_OK, arwt_pkg::KIND_STATUS,
                                              1'b0, '0, '0, '0, 1'b0, 1'b1);
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RD_HEAD;
                    end
                end
                S_RD_HEAD:
                begin
                    if (qcnt_reg == '0)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_reg <= mk_res(arwt_pkg::ST_OK, arwt_pkg::KIND_FINAL,
                                              1'b0, gen_reg, '0, '0, 1'b0, 1'b1);
                            need_empty_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg   <= head_idx;
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT:
                begin
                    state_reg <= S_RD_EMIT;
                end
                S_RD_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (hok_reg[idx_reg])
                        begin
                            out_reg <= mk_res(arwt_pkg::ST_OK, arwt_pkg::KIND_EVENT, 1'b1,
                                              ent_rd_reg.tag, clip_s, clip_e, 1'b0,
                                              (n_reg + 7'd1) == cmd_reg.lim);
                        end
                        else
                        begin
                            out_reg <= mk_res(arwt_pkg::ST_OK, arwt_pkg::KIND_EVENT, 1'b0,
                                              ent_rd_reg.tag, ent_rd_reg.lo,
                                              ent_rd_reg.hi, 1'b0,
                                              (n_reg + 7'd1) == cmd_reg.lim);
                        end
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                        begin
                            if (inval_reg[i] && (stamp_reg[i] != '0))
                            begin
                                stamp_reg[i] <= stamp_reg[i] - IDX_ONE;
                            end
                        end
                        inval_reg[idx_reg] <= 1'b0;
                        hok_reg[idx_reg]   <= 1'b0;
                        qcnt_reg           <= qcnt_reg - CNT_ONE;
                        need_empty_reg     <= 1'b1;
                        n_reg              <= n_reg + 7'd1;
                        state_reg <= ((n_reg + 7'd1) == cmd_reg.lim) ? S_IDLE : S_RD_HEAD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign event_kind      = out_reg.kind;
    assign hint_valid      = out_reg.hv;
    assign cookie_or_count = out_reg.coc;
    assign event_start     = out_reg.es;
    assign event_end       = out_reg.ee;
    assign hit             = out_reg.hit;
    assign last            = out_reg.last;

endmodule

`default_nettype wire

// ===== rtl/address_range_watch_table.sv =====
// ---------------------------------------------------------------------------
// address_range_watch_table - watched address range table, top level
// Registers, unregisters and invalidates cookie-tagged ranges and drains
// the resulting invalidation events.
// ---------------------------------------------------------------------------
// A two-deep command queue takes transactions while the table engine works,
// so up to two commands may wait ahead. The engine handles one command at a
// time and walks the table through a single registered read port, entry by
// entry. Register and unregister search the table for the cookie; invalidate
// runs one full walk per used range in start order plus a closing walk; a
// read drains queued events up to its limit. The result register lets the
// engine go on while a result waits to be taken. No clearing pass is needed
// after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module address_range_watch_table #(
    parameter int TABLE_ENTRIES = arwt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] cookie,
    input  wire logic [63:0] range_start,
    input  wire logic [63:0] range_end,
    input  wire logic [6:0]  max_events,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [1:0]       event_kind,
    output logic             hint_valid,
    output logic [63:0]      cookie_or_count,
    output logic [63:0]      event_start,
    output logic [63:0]      event_end,
    output logic             hit,
    output logic             last
);

    logic           cmd_valid;
    logic           cmd_pop;
    arwt_pkg::cmd_t cmd;

    // front end: accept and decode
    arwt_cmd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .cookie      (cookie),
        .range_start (range_start),
        .range_end   (range_end),
        .max_events  (max_events),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // back end: table walks and event output
    arwt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .event_kind      (event_kind),
        .hint_valid      (hint_valid),
        .cookie_or_count (cookie_or_count),
        .event_start     (event_start),
        .event_end       (event_end),
        .hit             (hit),
        .last            (last)
    );

endmodule

`default_nettype wire

// ===== rtl/arwt_checker.sv =====
// ---------------------------------------------------------------------------
// arwt_checker - port level checks for the watch table
// Result consistency checks, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module arwt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [1:0]  event_kind,
    input wire logic        hint_valid,
    input wire logic [63:0] cookie_or_count,
    input wire logic [63:0] event_start,
    input wire logic [63:0] event_end,
    input wire logic        hit,
    input wire logic        last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cookie_or_count) &&
        $stable(status) && $stable(event_kind) && $stable(hint_valid) &&
        $stable(event_start) && $stable(event_end) && $stable(hit) && $stable(last))
        else $error("stalled result changed");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == arwt_pkg::KIND_FINAL) |-> last && !hint_valid)
        else $error("final event not last");

    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != arwt_pkg::ST_OK) |->
        last && (event_kind == arwt_pkg::KIND_STATUS) && !hit)
        else $error("error result malformed");

    // a clipped hint only rides on an invalidation event
    a_hint_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hint_valid |-> (event_kind == arwt_pkg::KIND_EVENT))
        else $error("hint on non-event result");

endmodule

bind address_range_watch_table arwt_checker u_arwt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .event_kind      (event_kind),
    .hint_valid      (hint_valid),
    .cookie_or_count (cookie_or_count),
    .event_start     (event_start),
    .event_end       (event_end),
    .hit             (hit),
    .last            (last)
);

`default_nettype wire
